### rtl/core/pqe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqe_pkg: shared types and constants of the product-quantization encoder
// Holds the item structs, the action and result codes and the derived sizes.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam int unsigned Dim       = 64;
  localparam int unsigned Subspaces = 8;
  localparam int unsigned Ksub      = 256;
  localparam int unsigned Capacity  = 4096;

  localparam int unsigned Dsub     = ((Dim / Subspaces) > 0) ? (Dim / Subspaces) : 1;
  localparam int unsigned Vlen     = Subspaces * Dsub;
  localparam int unsigned CbDepth  = Ksub * Subspaces * Dsub;
  localparam int unsigned CsDepth  = Capacity * Subspaces;

  localparam int unsigned TW  = (Dsub > 1) ? $clog2(Dsub) : 1;
  localparam int unsigned SW  = (Subspaces > 1) ? $clog2(Subspaces) : 1;
  localparam int unsigned KW  = (Ksub > 1) ? $clog2(Ksub) : 1;
  localparam int unsigned VW  = $clog2(Vlen + 1);
  localparam int unsigned CBW = (CbDepth > 1) ? $clog2(CbDepth) : 1;
  localparam int unsigned EW  = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned NW  = $clog2(Capacity + 1);
  localparam int unsigned CSW = (CsDepth > 1) ? $clog2(CsDepth) : 1;
  localparam int unsigned DW  = 34 + TW;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_CODE     = 3'd0,
    KIND_STORED   = 3'd1,
    KIND_DROPPED  = 3'd2,
    KIND_REMOVED  = 3'd3,
    KIND_NOTFOUND = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [13:0]        codebook_address;
    logic signed [15:0] element_value;
    logic signed [31:0] entry_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  subspace;
    logic [7:0]  code;
    logic [12:0] entry_total;
  } out_item_t;

  // Queued command from the front part to the back part.
  typedef struct packed {
    logic               is_remove;
    logic [SW-1:0]      sub;
    logic signed [31:0] entry_id;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/core/pq_encode_code_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pq_encode_code_table: product-quantization encoder with code table
// Encodes streamed vectors to nearest-centroid codes and keeps an id table.
//
//   channel | signals                    | beat taken when
//   in      | start_i, item_i, busy_o    | start_i && !busy_o
//   out     | result_valid_o, result_o   | result_valid_o (one cycle)
//
// A closing element starts a search that reads the codebook one word a cycle from
// the single codebook RAM port before its result beat; closing the last subspace
// of a stored vector then writes its codes and id into the table. A remove scans
// the entries for the id and moves the last entry into the freed slot.
// After reset the table is empty. The result cannot be stalled; busy_o is
// high while a command is queued or the back part is working on one.
// ----------------------------------------------------------------------------
module pq_encode_code_table
  import pqe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire in_item_t item_i,
  output logic          busy_o,
  output logic          result_valid_o,
  output out_item_t     result_o
);
  logic           cb_we, cmd_valid, cmd_take, back_idle;
  logic [CBW-1:0] cb_waddr, cb_raddr;
  logic [15:0]    cb_wdata, cb_rdata;
  cmd_t           cmd;
  logic [TW-1:0]  sv_idx;
  logic signed [15:0] sv_data;

  pqe_front u_front (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o,
    .cb_we_o(cb_we), .cb_waddr_o(cb_waddr), .cb_wdata_o(cb_wdata),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take),
    .back_idle_i(back_idle), .sv_idx_i(sv_idx), .sv_data_o(sv_data));

  pqe_ram #(.Width(16), .Depth(CbDepth)) u_cb (
    .clk_i, .we_i(cb_we), .addr_i(cb_we ? cb_waddr : cb_raddr),
    .wdata_i(cb_wdata), .rdata_o(cb_rdata));

  pqe_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .idle_o(back_idle), .sv_idx_o(sv_idx), .sv_data_i(sv_data), .cb_raddr_o(cb_raddr),
    .cb_rdata_i(cb_rdata), .res_valid_o(result_valid_o), .res_o(result_o));
endmodule
`default_nettype wire

### rtl/core/pqe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqe_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module pqe_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

### rtl/core/pqe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqe_front: command intake
// Writes codebook words, buffers subvector elements and queues a search or a
// remove for the back part through a one-entry queue.
// ----------------------------------------------------------------------------
module pqe_front
  import pqe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire in_item_t item_i,
  output logic          busy_o,
  output logic          cb_we_o,
  output logic [CBW-1:0] cb_waddr_o,
  output logic [15:0]   cb_wdata_o,
  output logic          cmd_valid_o,
  output cmd_t          cmd_o,
  input  wire logic     cmd_take_i,
  input  wire logic     back_idle_i,
  input  wire logic [TW-1:0] sv_idx_i,
  output logic signed [15:0] sv_data_o
);
  logic signed [15:0] sv_q [Dsub];
  logic [VW-1:0] pos_q, pos_d, pos_c;
  logic          qv_q, qv_d;
  cmd_t          cmd_q, cmd_d;
  logic          acc;
  logic [TW-1:0] t_c;

  // The back part reads the subvector buffer and the codebook port while it
  // works, so intake holds off until it is idle again.
  assign busy_o      = qv_q || !back_idle_i;
  assign acc         = start_i && !busy_o;
  assign cmd_valid_o = qv_q;
  assign cmd_o       = cmd_q;
  assign sv_data_o   = sv_q[sv_idx_i];

  assign cb_we_o    = acc && (item_i.action == ACT_LOAD) &&
                      ({18'd0, item_i.codebook_address} < 32'(CbDepth));
  assign cb_waddr_o = CBW'(item_i.codebook_address);
  assign cb_wdata_o = item_i.element_value;

  always_comb begin
    pos_c = (pos_q >= VW'(Vlen)) ? '0 : pos_q;
    t_c   = TW'(32'(pos_c) % Dsub);
    pos_d = pos_q;
    qv_d  = qv_q && !cmd_take_i;
    cmd_d = cmd_q;
    if (acc && item_i.action == ACT_ADD) begin
      pos_d = (32'(pos_c) + 1 >= Vlen) ? '0 : pos_c + 1'b1;
      if (32'(t_c) == Dsub - 1) begin
        qv_d = 1'b1;
        cmd_d.is_remove = 1'b0;
        cmd_d.sub       = SW'(32'(pos_c) / Dsub);
        cmd_d.entry_id  = item_i.entry_id;
      end
    end else if (acc && item_i.action == ACT_REMOVE) begin
      qv_d = 1'b1;
      cmd_d.is_remove = 1'b1;
      cmd_d.sub       = '0;
      cmd_d.entry_id  = item_i.entry_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      qv_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      qv_q  <= qv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (acc && item_i.action == ACT_ADD) begin
      sv_q[t_c] <= item_i.element_value;
    end
  end
endmodule
`default_nettype wire

### rtl/core/pqe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pqe_back: nearest-centroid search and table maintenance
// Scans centroids one codebook word a cycle, stores vectors or removes entries.
// ----------------------------------------------------------------------------
module pqe_back
  import pqe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  wire cmd_t      cmd_i,
  output logic           cmd_take_o,
  output logic           idle_o,
  output logic [TW-1:0]  sv_idx_o,
  input  wire logic signed [15:0] sv_data_i,
  output logic [CBW-1:0] cb_raddr_o,
  input  wire logic [15:0] cb_rdata_i,
  output logic           res_valid_o,
  output out_item_t      res_o
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_FLUSH, ST_DONE, ST_STORE,
    ST_FIND, ST_FINDCHK, ST_MOVE, ST_MOVEWR, ST_RESULT
  } state_e;

  state_e st_q, st_d;
  cmd_t   cmd_q;
  logic [KW:0]   k_q, k_d;       // centroid being read
  logic [TW-1:0] t_q, t_d;       // word within centroid
  logic          rv_q;           // a codebook word arrives this cycle
  logic [KW-1:0] rk_q;
  logic [TW-1:0] rt_q;
  logic signed [15:0] rs_q;
  logic [31:0]   sq_q;
  logic          sqv_q, sqlast_q;
  logic [KW-1:0] sqk_q;
  logic [DW-1:0] acc_q, best_q;
  logic [KW-1:0] bestk_q;
  logic          seen_q;
  logic [7:0]    pend_q [Subspaces];
  logic [NW-1:0] cnt_q;
  logic [EW:0]   i_q, i_d;
  logic [SW:0]   m_q;
  logic [EW-1:0] hit_q;
  logic [2:0]    kind_q;

  // table memories
  logic          id_we, cs_we;
  logic [EW-1:0] id_addr;
  logic [31:0]   id_wdata, id_rdata;
  logic [CSW-1:0] cs_addr;
  logic [7:0]    cs_wdata, cs_rdata;

  pqe_ram #(.Width(32), .Depth(Capacity)) u_id (
    .clk_i, .we_i(id_we), .addr_i(id_addr), .wdata_i(id_wdata), .rdata_o(id_rdata));
  pqe_ram #(.Width(8), .Depth(CsDepth)) u_cs (
    .clk_i, .we_i(cs_we), .addr_i(cs_addr), .wdata_i(cs_wdata), .rdata_o(cs_rdata));

  logic [EW-1:0] last_e;
  assign last_e = EW'(cnt_q - 1'b1);

  assign idle_o     = (st_q == ST_IDLE);
  assign sv_idx_o   = t_q;
  assign cb_raddr_o = CBW'((32'(cmd_q.sub) * Ksub + 32'(k_q[KW-1:0])) * Dsub + 32'(t_q));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:    if (cmd_valid_i) st_d = cmd_i.is_remove ? ST_FIND : ST_SCAN;
      ST_SCAN:    if (32'(k_q) == Ksub - 1 && 32'(t_q) == Dsub - 1) st_d = ST_FLUSH;
      ST_FLUSH:   if (!rv_q && !sqv_q) st_d = ST_DONE;
      ST_DONE:    st_d = (32'(cmd_q.sub) == Subspaces - 1 && 32'(cnt_q) < Capacity)
                         ? ST_STORE : ST_RESULT;
      ST_STORE:   if (32'(m_q) == Subspaces - 1) st_d = ST_RESULT;
      ST_FIND:    st_d = (i_q >= (EW+1)'(cnt_q)) ? ST_RESULT : ST_FINDCHK;
      ST_FINDCHK: st_d = (id_rdata == cmd_q.entry_id) ? ST_MOVE : ST_FIND;
      ST_MOVE:    st_d = ST_MOVEWR;
      ST_MOVEWR:  st_d = (32'(m_q) == Subspaces) ? ST_RESULT : ST_MOVE;
      ST_RESULT:  st_d = ST_IDLE;
      default:    st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_take_o = (st_q == ST_IDLE) && cmd_valid_i;
    k_d = k_q;
    t_d = t_q;
    i_d = i_q;
    id_we = 1'b0; cs_we = 1'b0;
    id_addr = i_q[EW-1:0]; id_wdata = id_rdata;
    cs_addr = '0; cs_wdata = cs_rdata;
    if (st_q == ST_IDLE) begin
      k_d = '0; t_d = '0; i_d = '0;
    end
    if (st_q == ST_SCAN) begin
      if (32'(t_q) == Dsub - 1) begin
        t_d = '0; k_d = k_q + 1'b1;
      end else begin
        t_d = t_q + 1'b1;
      end
    end
    if (st_q == ST_STORE) begin
      cs_we    = 1'b1;
      cs_addr  = CSW'(32'(cnt_q) * Subspaces + 32'(m_q));
      cs_wdata = pend_q[m_q[SW-1:0]];
      id_we    = (m_q == '0);
      id_addr  = EW'(cnt_q);
      id_wdata = cmd_q.entry_id;
    end
    if (st_q == ST_FIND) begin
      id_addr = i_q[EW-1:0];
    end
    if (st_q == ST_FINDCHK && id_rdata != cmd_q.entry_id) begin
      i_d = i_q + 1'b1;
    end
    if (st_q == ST_MOVE) begin
      cs_addr = CSW'(32'(last_e) * Subspaces + 32'(m_q));
      id_addr = last_e;
    end
    if (st_q == ST_MOVEWR) begin
      cs_we   = 1'b1;
      cs_addr = CSW'(32'(hit_q) * Subspaces + 32'(m_q - 1'b1));
      id_we   = (m_q == (SW+1)'(1));
      id_addr = hit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      rv_q  <= 1'b0;
      sqv_q <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      st_q  <= st_d;
      rv_q  <= (st_q == ST_SCAN);
      sqv_q <= rv_q;
      res_valid_o <= (st_q == ST_RESULT);
      if (st_q == ST_STORE && 32'(m_q) == Subspaces - 1) cnt_q <= cnt_q + 1'b1;
      if (st_q == ST_MOVEWR && 32'(m_q) == Subspaces) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    t_q <= t_d;
    i_q <= i_d;
    rk_q <= k_q[KW-1:0];
    rt_q <= t_q;
    rs_q <= sv_data_i;
    if (cmd_take_o) cmd_q <= cmd_i;
    // squared difference stage
    if (rv_q) begin
      sq_q <= 32'(($signed({rs_q[15], rs_q}) - $signed({cb_rdata_i[15], cb_rdata_i})) *
                  ($signed({rs_q[15], rs_q}) - $signed({cb_rdata_i[15], cb_rdata_i})));
    end
    sqk_q    <= rk_q;
    sqlast_q <= (32'(rt_q) == Dsub - 1);
    // accumulate and compare
    if (st_q == ST_IDLE) begin
      acc_q <= '0; seen_q <= 1'b0; bestk_q <= '0;
    end else if (sqv_q) begin
      if (sqlast_q) begin
        acc_q <= '0;
        if (!seen_q || (acc_q + DW'(sq_q)) < best_q) begin
          best_q <= acc_q + DW'(sq_q);
          bestk_q <= sqk_q;
        end
        seen_q <= 1'b1;
      end else begin
        acc_q <= acc_q + DW'(sq_q);
      end
    end
    if (st_q == ST_DONE) begin
      pend_q[cmd_q.sub] <= 8'(bestk_q);
      kind_q <= (32'(cmd_q.sub) != Subspaces - 1) ? KIND_CODE :
                (32'(cnt_q) < Capacity) ? KIND_STORED : KIND_DROPPED;
    end
    if (st_q == ST_IDLE || st_q == ST_DONE || st_q == ST_FINDCHK) m_q <= '0;
    if (st_q == ST_STORE || st_q == ST_MOVE) m_q <= m_q + 1'b1;
    if (st_q == ST_FINDCHK && id_rdata == cmd_q.entry_id) hit_q <= i_q[EW-1:0];
    if (st_q == ST_FIND) kind_q <= (i_q >= (EW+1)'(cnt_q)) ? KIND_NOTFOUND : KIND_REMOVED;
    if (st_q == ST_RESULT) begin
      res_o.kind        <= kind_q;
      res_o.subspace    <= cmd_q.is_remove ? 3'd0 : 3'(cmd_q.sub);
      res_o.code        <= cmd_q.is_remove ? 8'd0 : 8'(bestk_q);
      res_o.entry_total <= 13'(cnt_q);
    end
  end
endmodule
`default_nettype wire

### bench/pq_encode_code_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pq_encode_code_table_tb: self-checking bench for the PQ encoder code table
// Fills the codebook, walks a directed table of loads, elements and removes,
// then drives random traffic with varying sender gaps. A behavioral encoder
// and table predict every result beat, which is compared as a whole item.
// ----------------------------------------------------------------------------
module pq_encode_code_table_tb;
  import pqe_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    action_e            act;
    logic [13:0]        addr;
    logic signed [15:0] val;
    logic signed [31:0] id;
    int                 reps;
    bit                 rnd_val;
    bit                 typed;
    out_item_t          exp;
  } row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  in_item_t  item_i;
  logic      busy_o;
  logic      result_valid_o;
  out_item_t result_o;

  // Behavioral copy of the encoder state.
  logic signed [15:0] cb_words[CbDepth];
  logic signed [15:0] sub_buf[Dsub];
  int unsigned        elem_pos;
  logic [7:0]         open_codes[Subspaces];
  logic [7:0]         table_codes[Capacity][Subspaces];
  logic signed [31:0] table_ids[Capacity];
  int unsigned        entries;

  out_item_t    result_q[$];
  row_t         rows[$];
  int           errors;
  int           idle_pct;
  int unsigned  idle_cycles;
  logic signed [31:0] id_pool[8];

  pq_encode_code_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] nearest_code(int unsigned sub);
    longint best;
    longint sq_sum;
    longint d;
    int unsigned best_k;
    int unsigned base;
    best = 0;
    best_k = 0;
    for (int unsigned k = 0; k < Ksub; k++) begin
      base = (sub * Ksub + k) * Dsub;
      sq_sum = 0;
      for (int unsigned t = 0; t < Dsub; t++) begin
        d = longint'(sub_buf[t]) - longint'(cb_words[base + t]);
        sq_sum += d * d;
      end
      // Strict compare keeps the lowest index on a tie.
      if (k == 0 || sq_sum < best) begin
        best = sq_sum;
        best_k = k;
      end
    end
    return best_k[7:0];
  endfunction

  function automatic bit predict_beat(in_item_t it, output out_item_t res);
    int unsigned pos;
    int unsigned sub;
    int unsigned slot;
    bit found;
    res = '0;
    case (action_e'(it.action))
      ACT_LOAD: begin
        if (it.codebook_address < CbDepth) cb_words[it.codebook_address] = it.element_value;
        return 1'b0;
      end
      ACT_ADD: begin
        pos = (elem_pos >= Vlen) ? 0 : elem_pos;
        sub_buf[pos % Dsub] = it.element_value;
        elem_pos = (pos + 1 >= Vlen) ? 0 : pos + 1;
        if ((pos % Dsub) != Dsub - 1) return 1'b0;
        sub = pos / Dsub;
        open_codes[sub] = nearest_code(sub);
        res.kind = KIND_CODE;
        if (sub == Subspaces - 1) begin
          if (entries < Capacity) begin
            for (int m = 0; m < Subspaces; m++) table_codes[entries][m] = open_codes[m];
            table_ids[entries] = it.entry_id;
            entries++;
            res.kind = KIND_STORED;
          end else begin
            res.kind = KIND_DROPPED;
          end
        end
        res.subspace = sub[2:0];
        res.code = open_codes[sub];
        res.entry_total = entries[12:0];
        return 1'b1;
      end
      ACT_REMOVE: begin
        found = 1'b0;
        slot = 0;
        for (int unsigned i = 0; i < entries; i++) begin
          if (!found && table_ids[i] == it.entry_id) begin
            found = 1'b1;
            slot = i;
          end
        end
        if (found) begin
          table_codes[slot] = table_codes[entries - 1];
          table_ids[slot] = table_ids[entries - 1];
          entries--;
        end
        res.kind = found ? KIND_REMOVED : KIND_NOTFOUND;
        res.entry_total = entries[12:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    return $urandom;
  endfunction

  // Drives one beat, waits for it to be taken, then books its result.
  task automatic send_beat(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t res;
    bit has_res;
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o);
    has_res = predict_beat(it, res);
    if (has_res) result_q = {result_q, (typed ? typed_res : res)};
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic add_row(action_e act, logic [13:0] addr, logic signed [15:0] val,
                         logic signed [31:0] id, int reps, bit rnd_val, bit typed,
                         out_item_t exp);
    row_t r;
    r.act = act;
    r.addr = addr;
    r.val = val;
    r.id = id;
    r.reps = reps;
    r.rnd_val = rnd_val;
    r.typed = typed;
    r.exp = exp;
    rows = {rows, r};
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual %p", $time, result_o);
        errors++;
      end else begin
        if (result_o !== result_q[0]) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, result_q[0], result_o);
          errors++;
        end
        void'(result_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("pq_encode_code_table_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    in_item_t  it;
    out_item_t none;
    int unsigned r;
    none = '0;
    errors = 0;
    idle_pct = 0;
    idle_cycles = 0;
    elem_pos = 0;
    entries = 0;
    id_pool = '{32'sh0, -32'sh1, 32'sh8000_0000, 32'sh7fff_ffff,
                32'sh1, 32'sh2, 32'sh3, 32'sh5a5a_5a5a};
    rst_ni  = 1'b0;
    start_i = 1'b0;
    item_i  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole codebook; subspace 0 stays all zero so all of its centroids tie.
    for (int unsigned a = 0; a < CbDepth; a++) begin
      it = '0;
      it.action = ACT_LOAD;
      it.codebook_address = a[13:0];
      it.element_value = (a < Ksub * Dsub) ? 16'sh0 : pick_value();
      send_beat(it, 1'b0, none);
    end

    add_row(ACT_REMOVE, 0, 0, 0, 1, 0, 1, '{KIND_NOTFOUND, 3'd0, 8'd0, 13'd0});
    add_row(ACT_NONE, 14'h3fff, -16'sh1, -32'sh1, 1, 0, 0, none);
    add_row(ACT_ADD, 0, 16'sh8000, 0, 1, 0, 0, none);
    add_row(ACT_ADD, 0, 16'sh7fff, 0, 1, 0, 0, none);
    add_row(ACT_ADD, 14'h2aaa, 0, 32'sh1234_5678, 5, 1, 0, none);
    add_row(ACT_ADD, 0, 0, 0, 1, 0, 1, '{KIND_CODE, 3'd0, 8'd0, 13'd0});
    // Load and remove in the middle of a vector leave the partial vector intact.
    add_row(ACT_LOAD, 14'h3fff, 16'sh7fff, 0, 1, 0, 0, none);
    add_row(ACT_REMOVE, 0, 0, 32'sh5, 1, 0, 1, '{KIND_NOTFOUND, 3'd0, 8'd0, 13'd0});
    add_row(ACT_ADD, 0, 0, 0, 55, 1, 0, none);
    add_row(ACT_ADD, 0, 0, 32'sh8000_0000, 1, 1, 0, none);
    add_row(ACT_ADD, 0, 0, 0, 63, 1, 0, none);
    add_row(ACT_ADD, 0, 0, 32'sh7fff_ffff, 1, 1, 0, none);
    add_row(ACT_ADD, 0, 0, 0, 63, 1, 0, none);
    add_row(ACT_ADD, 0, 0, 32'sh8000_0000, 1, 1, 0, none);
    // The duplicate id goes away one entry at a time.
    add_row(ACT_REMOVE, 0, 0, 32'sh8000_0000, 1, 0, 1, '{KIND_REMOVED, 3'd0, 8'd0, 13'd2});
    add_row(ACT_REMOVE, 0, 0, 32'sh8000_0000, 1, 0, 1, '{KIND_REMOVED, 3'd0, 8'd0, 13'd1});
    add_row(ACT_REMOVE, 0, 0, 32'sh8000_0000, 1, 0, 1, '{KIND_NOTFOUND, 3'd0, 8'd0, 13'd1});

    foreach (rows[i]) begin
      for (int k = 0; k < rows[i].reps; k++) begin
        it.action = rows[i].act;
        it.codebook_address = rows[i].addr;
        it.element_value = rows[i].rnd_val ? pick_value() : rows[i].val;
        it.entry_id = rows[i].id;
        send_beat(it, rows[i].typed, rows[i].exp);
      end
    end

    for (int n = 0; n < 450; n++) begin
      idle_pct = (n < 150) ? 30 : (n < 300) ? 75 : 0;
      if (n == 200) begin
        start_i <= 1'b0;
        while (result_q.size() != 0) @(posedge clk_i);
      end
      r = $urandom_range(99);
      it.action = (r < 65) ? ACT_ADD : (r < 80) ? ACT_REMOVE : (r < 93) ? ACT_LOAD : ACT_NONE;
      it.codebook_address = $urandom;
      it.element_value = pick_value();
      it.entry_id = ($urandom_range(3) == 0) ? $urandom : id_pool[$urandom_range(7)];
      send_beat(it, 1'b0, none);
    end
    start_i <= 1'b0;

    while (result_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("pq_encode_code_table_tb: done, clean");
    end else begin
      $display("pq_encode_code_table_tb: done, errors");
    end
    $finish;
  end

endmodule
